[rtl/assert_macros.svh]
// Assertion macros shared by the autotile source select RTL.
// Included by the files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising clock edge, idle while reset is asserted.
`define ATSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`endif

[rtl/atss_pkg.sv]
// Package for the autotile source select block: field widths, texture mode
// codes, the tile classification record and the classification function.
// No dependencies.
package atss_pkg;

  // Input and output field widths
  localparam int MODE_W   = 3;
  localparam int VC_W     = 5;
  localparam int POS_W    = 8;
  localparam int NB_W     = 8;
  localparam int SRC_X_W  = 9;
  localparam int SRC_Y_W  = 7;
  localparam int S_DATA_W = 40;  // 34 bits of fields, padded to bytes
  localparam int M_DATA_W = 16;

  // Sprite index widths
  localparam int CX_W = 4;
  localparam int CY_W = 2;

  // Remainder unit: 16-bit dividend, divisor 0..16, four bits per stage
  localparam int PROD_W       = 16;
  localparam int REM_W        = 4;
  localparam int BITS_PER_STG = 4;
  localparam int NUM_REM_STG  = PROD_W / BITS_PER_STG;
  localparam logic [VC_W-1:0] MAX_VARIANTS = VC_W'(16);

  // Neighbor match bit positions
  localparam int NB_ABOVE = 0;
  localparam int NB_LEFT  = 1;
  localparam int NB_BELOW = 2;
  localparam int NB_RIGHT = 3;
  localparam int NB_UL    = 4;
  localparam int NB_UR    = 5;
  localparam int NB_DL    = 6;
  localparam int NB_DR    = 7;

  typedef enum logic [MODE_W-1:0] {
    MODE_PLAIN  = 3'd0,
    MODE_RANDOM = 3'd1,
    MODE_HORIZ  = 3'd2,
    MODE_VERT   = 3'd3,
    MODE_SIDE   = 3'd4,
    MODE_FULL   = 3'd5
  } tex_mode_e;

  // Sprite index for one tile; use_rand picks the remainder as column
  typedef struct packed {
    logic            use_rand;
    logic [CX_W-1:0] cx;
    logic [CY_W-1:0] cy;
  } tile_cls_t;

  // Per-stage payload of the remainder pipeline
  typedef struct packed {
    logic [PROD_W-1:0] prod;
    logic [REM_W-1:0]  rem;
    logic [VC_W-1:0]   vc;
    tile_cls_t         cls;
  } stage_pl_t;

  // Clamp the random variant count to the sheet's maximum
  function automatic logic [VC_W-1:0] clamp_vc(logic [VC_W-1:0] vc);
    return (vc > MAX_VARIANTS) ? MAX_VARIANTS : vc;
  endfunction

  // Pick the sprite index from door state, texture mode and neighbors
  function automatic tile_cls_t classify(logic door, logic open,
                                         logic [MODE_W-1:0] mode,
                                         logic [VC_W-1:0] vc_c,
                                         logic [NB_W-1:0] nb);
    tile_cls_t c;
    logic a, l, b, r, ul, ur, dl, dr;
    a  = nb[NB_ABOVE];
    l  = nb[NB_LEFT];
    b  = nb[NB_BELOW];
    r  = nb[NB_RIGHT];
    ul = nb[NB_UL];
    ur = nb[NB_UR];
    dl = nb[NB_DL];
    dr = nb[NB_DR];
    c  = '0;
    if (door) begin
      c.cx = CX_W'(open);
    end else begin
      unique case (tex_mode_e'(mode))
        MODE_RANDOM: begin
          c.use_rand = (vc_c != '0);
        end
        MODE_HORIZ: begin
          priority if (l && r) c.cx = CX_W'(1);
          else if (r)          c.cx = CX_W'(0);
          else if (l)          c.cx = CX_W'(2);
          else                 c.cx = CX_W'(3);
        end
        MODE_VERT: begin
          priority if (a && b) c.cy = CY_W'(1);
          else if (b)          c.cy = CY_W'(0);
          else if (a)          c.cy = CY_W'(2);
          else                 c.cy = CY_W'(3);
        end
        MODE_SIDE: begin
          if (a && b && l && r) begin
            // inner corner pieces; all corners matching leaves zero
            if (!ul)      begin c.cx = CX_W'(1); c.cy = CY_W'(2); end
            else if (!ur) begin c.cx = CX_W'(0); c.cy = CY_W'(2); end
            else if (!dl) begin c.cx = CX_W'(1); c.cy = CY_W'(1); end
            else if (!dr) begin c.cx = CX_W'(0); c.cy = CY_W'(1); end
          end
          else if (!a && b && l && r)  begin c.cx = CX_W'(3); c.cy = CY_W'(0); end
          else if (a && !b && l && r)  begin c.cx = CX_W'(3); c.cy = CY_W'(2); end
          else if (a && b && !l && r)  begin c.cx = CX_W'(2); c.cy = CY_W'(1); end
          else if (a && b && l && !r)  begin c.cx = CX_W'(4); c.cy = CY_W'(1); end
          else if (!a && b && !l && r) begin c.cx = CX_W'(2); c.cy = CY_W'(0); end
          else if (!a && b && l && !r) begin c.cx = CX_W'(4); c.cy = CY_W'(0); end
          else if (a && !b && !l && r) begin c.cx = CX_W'(2); c.cy = CY_W'(2); end
          else if (a && !b && l && !r) begin c.cx = CX_W'(4); c.cy = CY_W'(2); end
        end
        MODE_FULL: begin
          c.cx = {r, b, l, a};
          if ((a && l && ul) || (a && r && ur) || (b && l && dl) || (b && r && dr))
            c.cy = CY_W'(1);
          if (a && l && b && r) begin
            if (!ul && !ur && !dl && !dr) c.cy = CY_W'(1);
            // single missing corner selects a dedicated piece
            if (!ul && ur && dl && dr)      begin c.cx = CX_W'(5); c.cy = CY_W'(2); end
            else if (ul && !ur && dl && dr) begin c.cx = CX_W'(4); c.cy = CY_W'(2); end
            else if (ul && ur && !dl && dr) begin c.cx = CX_W'(5); c.cy = CY_W'(1); end
            else if (ul && ur && dl && !dr) begin c.cx = CX_W'(4); c.cy = CY_W'(1); end
          end
        end
        default: begin
          c = '0;  // plain and unused codes
        end
      endcase
    end
    return c;
  endfunction

endpackage

[rtl/atss_rem_stage.sv]
// One slice of the restoring remainder unit: four dividend bits per slice.
// Depends on atss_pkg.
module atss_rem_stage
  import atss_pkg::*;
(
  input  logic [REM_W-1:0]        rem_i,
  input  logic [BITS_PER_STG-1:0] bits_i,   // next dividend bits, MSB first
  input  logic [VC_W-1:0]         div_i,
  output logic [REM_W-1:0]        rem_o
);

  // Shift in each dividend bit, MSB first, subtracting the divisor when it fits
  always_comb begin
    logic [REM_W:0] t;
    t = {1'b0, rem_i};
    for (int i = BITS_PER_STG - 1; i >= 0; i--) begin
      t = {t[REM_W-1:0], bits_i[i]};
      if (t >= (REM_W + 1)'(div_i)) t = t - (REM_W + 1)'(div_i);
    end
    rem_o = t[REM_W-1:0];
  end

endmodule

[rtl/autotile_source_select_core.sv]
// Top level of the autotile source select block: classification, remainder
// pipeline and output scaling. Depends on atss_pkg, atss_rem_stage and
// assert_macros.svh.

// Each tile transfer yields one result: the sprite-sheet source offset in
// pixels. The pipeline takes one tile per cycle unless the output stalls
// with every stage full. The random column is the remainder (x + y*x) mod
// variant count. A product stage comes first, and the remainder is then
// worked out four dividend bits per stage over four stages. A final stage
// scales the sprite index by TILE_SIZE and registers the result. Every
// stage carries a valid bit and loads when it is empty or the stage after
// it loads, so bubbles close up. While a finished result waits at the
// output, a new tile is still taken as long as an earlier stage is empty.
`include "assert_macros.svh"

module autotile_source_select_core
  import atss_pkg::*;
#(
  parameter int TILE_SIZE = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // is_door[0], door_open[1], tex_mode[4:2], variant_count[9:5],
  // pos_x[17:10], pos_y[25:18], neighbor_match[33:26], zero pad
  input  logic [S_DATA_W-1:0] s_axis_tdata,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // src_x_px[8:0], src_y_px[15:9]
  output logic [M_DATA_W-1:0] m_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready
);

  localparam int TS_W  = $clog2(TILE_SIZE + 1);
  localparam int XP_W  = (CX_W + TS_W > SRC_X_W) ? CX_W + TS_W : SRC_X_W;
  localparam int YP_W  = (CY_W + TS_W > SRC_Y_W) ? CY_W + TS_W : SRC_Y_W;
  localparam int NSTG  = NUM_REM_STG + 2;  // product, remainder slices, output
  localparam int LAST  = NSTG - 1;

  // Input field unpack
  logic              in_door;
  logic              in_open;
  logic [MODE_W-1:0] in_mode;
  logic [VC_W-1:0]   in_vc;
  logic [POS_W-1:0]  in_x;
  logic [POS_W-1:0]  in_y;
  logic [NB_W-1:0]   in_nb;

  assign in_door = s_axis_tdata[0];
  assign in_open = s_axis_tdata[1];
  assign in_mode = s_axis_tdata[4:2];
  assign in_vc   = s_axis_tdata[9:5];
  assign in_x    = s_axis_tdata[17:10];
  assign in_y    = s_axis_tdata[25:18];
  assign in_nb   = s_axis_tdata[33:26];

  logic [NSTG-1:0]       vld_q;
  logic [NSTG-1:0]       en;
  stage_pl_t             pl_q [NUM_REM_STG+1];
  stage_pl_t             pl_d [NUM_REM_STG+1];
  logic [SRC_X_W-1:0]    src_x_q, src_x_d;
  logic [SRC_Y_W-1:0]    src_y_q, src_y_d;
  logic                  rem_in_range;

  // Stage load enables: a stage loads when empty or when it drains
  always_comb begin
    en[LAST] = !vld_q[LAST] || m_axis_tready;
    for (int k = LAST - 1; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign s_axis_tready = en[0];

  // Product stage: x*(y+1) and sprite classification
  always_comb begin
    logic [VC_W-1:0] vc_c;
    vc_c            = clamp_vc(in_vc);
    pl_d[0].prod    = PROD_W'((PROD_W + 1)'(in_x) * ((PROD_W + 1)'(in_y) + 17'd1));
    pl_d[0].rem     = '0;
    pl_d[0].vc      = vc_c;
    pl_d[0].cls     = classify(in_door, in_open, in_mode, vc_c, in_nb);
  end

  // Remainder slices, most significant dividend bits first
  for (genvar k = 1; k <= NUM_REM_STG; k++) begin : g_rem
    logic [REM_W-1:0] rem_nxt;

    atss_rem_stage u_rem (
      .rem_i  (pl_q[k-1].rem),
      .bits_i (pl_q[k-1].prod[PROD_W-1-(k-1)*BITS_PER_STG -: BITS_PER_STG]),
      .div_i  (pl_q[k-1].vc),
      .rem_o  (rem_nxt)
    );

    always_comb begin
      pl_d[k]     = pl_q[k-1];
      pl_d[k].rem = rem_nxt;
    end
  end

  // Output stage: final column select and scaling by the tile size
  always_comb begin
    logic [CX_W-1:0] cx_fin;
    logic [XP_W-1:0] xp;
    logic [YP_W-1:0] yp;
    cx_fin  = pl_q[NUM_REM_STG].cls.use_rand ? CX_W'(pl_q[NUM_REM_STG].rem)
                                             : pl_q[NUM_REM_STG].cls.cx;
    xp      = XP_W'(cx_fin) * XP_W'(TILE_SIZE);
    yp      = YP_W'(pl_q[NUM_REM_STG].cls.cy) * YP_W'(TILE_SIZE);
    src_x_d = xp[SRC_X_W-1:0];
    src_y_d = yp[SRC_Y_W-1:0];
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= s_axis_tvalid;
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    for (int k = 0; k <= NUM_REM_STG; k++) begin
      if (en[k]) pl_q[k] <= pl_d[k];
    end
    if (en[LAST]) begin
      src_x_q <= src_x_d;
      src_y_q <= src_y_d;
    end
  end

  assign m_axis_tvalid = vld_q[LAST];
  assign m_axis_tdata  = {src_y_q, src_x_q};

  // Remainder of the last slice stays below a nonzero divisor
  assign rem_in_range = (pl_q[NUM_REM_STG].vc == '0) ||
                        (VC_W'(pl_q[NUM_REM_STG].rem) < pl_q[NUM_REM_STG].vc);

  // Checks
  `ATSS_ASSERT(a_adv_first, vld_q[0] && en[1] |=> vld_q[1], "item lost after product stage")
  `ATSS_ASSERT(a_rem_bound, vld_q[NUM_REM_STG] |-> rem_in_range, "remainder not below divisor")
  `ATSS_ASSERT(a_full_stall, !en[0] |-> vld_q[LAST] && !m_axis_tready, "bad input stall")

endmodule
